/* hdl/clt_pkg.sv */
package clt_pkg;

  // request codes
  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_CHAR   = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_GLYPH  = 3'd4;
  localparam logic [2:0] ACT_NUMBER = 3'd5;

  // bus timing values
  localparam logic [10:0] PULSE_LONG   = 11'd2000;
  localparam logic [10:0] PULSE_SHORT  = 11'd1;
  localparam logic [15:0] WAIT_PWR_8   = 16'd35000;
  localparam logic [15:0] WAIT_PWR_4   = 16'd20000;

  // init sequence lengths, as index of the final byte
  localparam logic [2:0] INIT8_LAST = 3'd3;
  localparam logic [2:0] INIT4_LAST = 3'd6;

  // decimal printing: five places, most significant first
  localparam logic [2:0] DIGIT_LAST = 3'd4;
  localparam logic [7:0] ASCII_ZERO = 8'd48;

  // line base addresses and glyph address base
  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;
  localparam logic [7:0] CGRAM_BASE = 8'h40;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load_byte;
    logic step_div;
    logic load_digit;
    logic next_digit;
    logic next_init;
    logic emit_hi;
    logic emit_lo;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] action;
    logic       row_valid;
    logic       nibble_mode;
    logic       last;
    logic       rem_ge_pow;
    logic       digit_show;
  } dp_stat_t;

  // init command bytes
  function automatic logic [7:0] init_byte(input logic mode, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (mode) begin
      case (idx)
        3'd0: b = 8'h03;
        3'd1: b = 8'h03;
        3'd2: b = 8'h03;
        3'd3: b = 8'h02;
        3'd4: b = 8'h28;
        3'd5: b = 8'h0C;
        3'd6: b = 8'h80;
        default: b = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0: b = 8'h38;
        3'd1: b = 8'h0C;
        3'd2: b = 8'h01;
        3'd3: b = 8'h06;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // extra wait after each init byte
  function automatic logic [12:0] init_wait(input logic mode, input logic [2:0] idx);
    logic [12:0] w;
    w = 13'd0;
    if (mode) begin
      case (idx)
        3'd0: w = 13'd5000;
        3'd1: w = 13'd100;
        default: w = 13'd0;
      endcase
    end else begin
      case (idx)
        3'd0: w = 13'd1000;
        3'd1: w = 13'd1000;
        3'd2: w = 13'd2000;
        3'd3: w = 13'd2000;
        default: w = 13'd0;
      endcase
    end
    return w;
  endfunction

  // decimal place weights
  function automatic logic [13:0] pow_of_ten(input logic [2:0] idx);
    logic [13:0] p;
    case (idx)
      3'd0: p = 14'd10000;
      3'd1: p = 14'd1000;
      3'd2: p = 14'd100;
      3'd3: p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

/* hdl/char_lcd_transfer_sequencer.sv */
// Character LCD transfer sequencer: turns one display request into the run of
// bus transfers (register select, bus value, enable width, waits) for the panel.
// Request channel: drive action_i and its operands with start_i high; the
// request is taken at a clock edge where start_i is high and busy_o is low.
// Operands are sampled only at that edge.
// Result channel: each transfer appears on the result ports for one cycle with
// result_strobe_o high; last_o marks the final transfer of a request. The
// receiver cannot stall, so every strobe is a delivered transfer.
// Configuration: nibble_mode_we_i writes nibble_mode_i (0 = 8-bit, 1 = 4-bit);
// write only while busy_o is low and no transfer is pending.
// Timing: after the accepting edge the request is decoded in the load state;
// each transfer is then formed in the high or low nibble state and shows on
// the ports in the following cycle, from the result register. A number is
// converted by repeated subtraction of the place weight, one per cycle, then
// each of the five places is closed and each printed digit is sent.
// Rows 2 and 3 and unused actions produce no transfers and end in the load state.
// Reset clears the controller, the strobe and nibble mode.
module char_lcd_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] number_i,
  input  logic [1:0]  row_i,
  input  logic [5:0]  column_i,
  input  logic [2:0]  glyph_slot_i,
  input  logic        nibble_mode_we_i,
  input  logic        nibble_mode_i,
  output logic        result_strobe_o,
  output logic        register_select_o,
  output logic [7:0]  bus_value_o,
  output logic [10:0] enable_pulse_us_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_o
);

  clt_pkg::ctl_cmd_t cmd;
  clt_pkg::dp_stat_t stat;

  // sequencing controller
  clt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // request registers, digit loop and result register
  clt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .nibble_mode_we_i  (nibble_mode_we_i),
    .nibble_mode_i     (nibble_mode_i),
    .action_i          (action_i),
    .byte_value_i      (byte_value_i),
    .number_i          (number_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .glyph_slot_i      (glyph_slot_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .result_strobe_o   (result_strobe_o),
    .register_select_o (register_select_o),
    .bus_value_o       (bus_value_o),
    .enable_pulse_us_o (enable_pulse_us_o),
    .wait_before_us_o  (wait_before_us_o),
    .wait_after_us_o   (wait_after_us_o),
    .last_o            (last_o)
  );

endmodule

/* hdl/clt_ctrl.sv */
module clt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  clt_pkg::dp_stat_t stat_i,
  output clt_pkg::ctl_cmd_t cmd_o,
  output logic              busy_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_HI   = 5'b01000,
    S_LO   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat_i.action == clt_pkg::ACT_NUMBER) begin
          state_d = S_DIV;
        end else if (stat_i.action == clt_pkg::ACT_INIT ||
                     stat_i.action == clt_pkg::ACT_CMD ||
                     stat_i.action == clt_pkg::ACT_CHAR ||
                     stat_i.action == clt_pkg::ACT_GLYPH ||
                     (stat_i.action == clt_pkg::ACT_CURSOR && stat_i.row_valid)) begin
          cmd_o.load_byte = 1'b1;
          state_d         = S_HI;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.rem_ge_pow) begin
          cmd_o.step_div = 1'b1;
        end else if (stat_i.digit_show) begin
          cmd_o.load_digit = 1'b1;
          state_d          = S_HI;
        end else begin
          cmd_o.next_digit = 1'b1;
        end
      end
      S_HI: begin
        cmd_o.emit_hi = 1'b1;
        if (stat_i.nibble_mode) begin
          state_d = S_LO;
        end else if (stat_i.last) begin
          state_d = S_IDLE;
        end else if (stat_i.action == clt_pkg::ACT_NUMBER) begin
          cmd_o.next_digit = 1'b1;
          state_d          = S_DIV;
        end else begin
          cmd_o.next_init = 1'b1;
          state_d         = S_LOAD;
        end
      end
      S_LO: begin
        cmd_o.emit_lo = 1'b1;
        if (stat_i.last) begin
          state_d = S_IDLE;
        end else if (stat_i.action == clt_pkg::ACT_NUMBER) begin
          cmd_o.next_digit = 1'b1;
          state_d          = S_DIV;
        end else begin
          cmd_o.next_init = 1'b1;
          state_d         = S_LOAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/clt_datapath.sv */
module clt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              nibble_mode_we_i,
  input  logic              nibble_mode_i,
  input  logic [2:0]        action_i,
  input  logic [7:0]        byte_value_i,
  input  logic [15:0]       number_i,
  input  logic [1:0]        row_i,
  input  logic [5:0]        column_i,
  input  logic [2:0]        glyph_slot_i,
  input  clt_pkg::ctl_cmd_t cmd_i,
  output clt_pkg::dp_stat_t stat_o,
  output logic              result_strobe_o,
  output logic              register_select_o,
  output logic [7:0]        bus_value_o,
  output logic [10:0]       enable_pulse_us_o,
  output logic [15:0]       wait_before_us_o,
  output logic [12:0]       wait_after_us_o,
  output logic              last_o
);

  // configuration and captured request
  logic        mode_q;
  logic [2:0]  act_q;
  logic [7:0]  bv_q;
  logic [1:0]  row_q;
  logic [5:0]  col_q;
  logic [2:0]  slot_q;

  // digit extraction and init sequencing
  logic [15:0] rem_q;
  logic [3:0]  digit_q;
  logic [2:0]  pow_idx_q;
  logic        started_q;
  logic [2:0]  init_idx_q;
  logic [13:0] pow;

  // current byte and its transfer attributes
  logic [7:0]  byte_q, byte_d;
  logic        rs_q, rs_d;
  logic [15:0] wb_q, wb_d;
  logic [12:0] wa_q, wa_d;
  logic        last_q, last_d;

  // result register
  logic        strobe_q;
  logic        out_rs_q;
  logic [7:0]  out_bus_q;
  logic [10:0] out_pulse_q;
  logic [15:0] out_wb_q;
  logic [12:0] out_wa_q;
  logic        out_last_q;
  logic [10:0] pulse;

  assign pow = clt_pkg::pow_of_ten(pow_idx_q);

  // status toward the controller
  assign stat_o.action      = act_q;
  assign stat_o.row_valid   = (row_q[1] == 1'b0);
  assign stat_o.nibble_mode = mode_q;
  assign stat_o.last        = last_q;
  assign stat_o.rem_ge_pow  = (rem_q >= {2'b00, pow});
  assign stat_o.digit_show  = (digit_q != 4'd0) || started_q ||
                              (pow_idx_q == clt_pkg::DIGIT_LAST);

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (nibble_mode_we_i) begin
      mode_q <= nibble_mode_i;
    end
  end

  // byte selection for the current step
  always_comb begin
    byte_d = byte_q;
    rs_d   = rs_q;
    wb_d   = wb_q;
    wa_d   = wa_q;
    last_d = last_q;
    if (cmd_i.load_byte) begin
      rs_d   = 1'b0;
      wb_d   = 16'd0;
      wa_d   = 13'd0;
      last_d = 1'b1;
      case (act_q)
        clt_pkg::ACT_INIT: begin
          byte_d = clt_pkg::init_byte(mode_q, init_idx_q);
          wa_d   = clt_pkg::init_wait(mode_q, init_idx_q);
          if (init_idx_q == 3'd0) begin
            wb_d = mode_q ? clt_pkg::WAIT_PWR_4 : clt_pkg::WAIT_PWR_8;
          end
          last_d = (init_idx_q == (mode_q ? clt_pkg::INIT4_LAST : clt_pkg::INIT8_LAST));
        end
        clt_pkg::ACT_CMD: begin
          byte_d = bv_q;
        end
        clt_pkg::ACT_CHAR: begin
          byte_d = bv_q;
          rs_d   = 1'b1;
        end
        clt_pkg::ACT_CURSOR: begin
          byte_d = (row_q[0] ? clt_pkg::LINE1_BASE : clt_pkg::LINE0_BASE) +
                   {2'b00, col_q};
        end
        clt_pkg::ACT_GLYPH: begin
          byte_d = clt_pkg::CGRAM_BASE + {2'b00, slot_q, 3'b000};
        end
        default: begin
          byte_d = bv_q;
        end
      endcase
    end else if (cmd_i.load_digit) begin
      byte_d = clt_pkg::ASCII_ZERO + {4'b0000, digit_q};
      rs_d   = 1'b1;
      wb_d   = 16'd0;
      wa_d   = 13'd0;
      last_d = (pow_idx_q == clt_pkg::DIGIT_LAST);
    end
  end

  // request capture, digit loop and init counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (cmd_i.capture) begin
      started_q <= 1'b0;
    end else if (cmd_i.load_digit) begin
      started_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q      <= action_i;
      bv_q       <= byte_value_i;
      row_q      <= row_i;
      col_q      <= column_i;
      slot_q     <= glyph_slot_i;
      rem_q      <= number_i;
      digit_q    <= 4'd0;
      pow_idx_q  <= 3'd0;
      init_idx_q <= 3'd0;
    end else begin
      if (cmd_i.step_div) begin
        rem_q   <= rem_q - {2'b00, pow};
        digit_q <= digit_q + 4'd1;
      end
      if (cmd_i.next_digit) begin
        pow_idx_q <= pow_idx_q + 3'd1;
        digit_q   <= 4'd0;
      end
      if (cmd_i.next_init) begin
        init_idx_q <= init_idx_q + 3'd1;
      end
    end
    byte_q <= byte_d;
    rs_q   <= rs_d;
    wb_q   <= wb_d;
    wa_q   <= wa_d;
    last_q <= last_d;
  end

  // command nibbles get a short enable pulse
  assign pulse = (mode_q && !rs_q) ? clt_pkg::PULSE_SHORT : clt_pkg::PULSE_LONG;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_hi || cmd_i.emit_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hi) begin
      out_rs_q    <= rs_q;
      out_pulse_q <= pulse;
      out_wb_q    <= wb_q;
      if (mode_q) begin
        out_bus_q  <= {4'b0000, byte_q[7:4]};
        out_wa_q   <= 13'd0;
        out_last_q <= 1'b0;
      end else begin
        out_bus_q  <= byte_q;
        out_wa_q   <= wa_q;
        out_last_q <= last_q;
      end
    end else if (cmd_i.emit_lo) begin
      out_rs_q    <= rs_q;
      out_pulse_q <= pulse;
      out_wb_q    <= 16'd0;
      out_bus_q   <= {4'b0000, byte_q[3:0]};
      out_wa_q    <= wa_q;
      out_last_q  <= last_q;
    end
  end

  assign result_strobe_o   = strobe_q;
  assign register_select_o = out_rs_q;
  assign bus_value_o       = out_bus_q;
  assign enable_pulse_us_o = out_pulse_q;
  assign wait_before_us_o  = out_wb_q;
  assign wait_after_us_o   = out_wa_q;
  assign last_o            = out_last_q;

endmodule

/* tb/char_lcd_transfer_checker.sv */
module char_lcd_transfer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] number_i,
  input  logic [1:0]  row_i,
  input  logic [5:0]  column_i,
  input  logic [2:0]  glyph_slot_i,
  input  logic        nibble_mode_we_i,
  input  logic        nibble_mode_i,
  input  logic        result_strobe_i,
  input  logic        register_select_i,
  input  logic [7:0]  bus_value_i,
  input  logic [10:0] enable_pulse_us_i,
  input  logic [15:0] wait_before_us_i,
  input  logic [12:0] wait_after_us_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  // one bus transfer as seen on the result ports
  typedef struct packed {
    logic        rs;
    logic [7:0]  bus;
    logic [10:0] pulse;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } xfer_t;

  xfer_t pending_xfers[$];
  logic  four_bit_bus;
  int    errors = 0;

  // one byte becomes one transfer, or two nibble transfers on a 4-bit bus
  function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                     input logic [15:0] wb, input logic [12:0] wa);
    xfer_t t;
    t.rs = rs;
    t.last = 1'b0;
    if (four_bit_bus) begin
      t.pulse = rs ? clt_pkg::PULSE_LONG : clt_pkg::PULSE_SHORT;
      t.bus = {4'h0, b[7:4]};
      t.wait_before = wb;
      t.wait_after = '0;
      pending_xfers.push_back(t);
      t.bus = {4'h0, b[3:0]};
      t.wait_before = '0;
      t.wait_after = wa;
      pending_xfers.push_back(t);
    end else begin
      t.pulse = clt_pkg::PULSE_LONG;
      t.bus = b;
      t.wait_before = wb;
      t.wait_after = wa;
      pending_xfers.push_back(t);
    end
  endfunction

  // decimal digits, most significant first, no leading zeros
  function automatic void queue_number(input logic [15:0] n);
    int  rem;
    int  weight;
    int  digit;
    bit  printing;
    rem = n;
    weight = 10000;
    printing = 1'b0;
    if (n == 16'd0) begin
      queue_byte(1'b1, clt_pkg::ASCII_ZERO, '0, '0);
    end else begin
      while (weight != 0) begin
        digit = rem / weight;
        rem = rem % weight;
        if (digit != 0 || printing) begin
          printing = 1'b1;
          queue_byte(1'b1, clt_pkg::ASCII_ZERO + 8'(digit), '0, '0);
        end
        weight = weight / 10;
      end
    end
  endfunction

  // expected transfers for one accepted request
  function automatic void predict_request(input logic [2:0] act, input logic [7:0] bv,
                                          input logic [15:0] num, input logic [1:0] row,
                                          input logic [5:0] col, input logic [2:0] slot);
    int    before_size;
    xfer_t tail;
    before_size = pending_xfers.size();
    case (act)
      clt_pkg::ACT_INIT: begin
        if (four_bit_bus) begin
          queue_byte(1'b0, 8'h03, clt_pkg::WAIT_PWR_4, 13'd5000);
          queue_byte(1'b0, 8'h03, '0, 13'd100);
          queue_byte(1'b0, 8'h03, '0, '0);
          queue_byte(1'b0, 8'h02, '0, '0);
          queue_byte(1'b0, 8'h28, '0, '0);
          queue_byte(1'b0, 8'h0C, '0, '0);
          queue_byte(1'b0, 8'h80, '0, '0);
        end else begin
          queue_byte(1'b0, 8'h38, clt_pkg::WAIT_PWR_8, 13'd1000);
          queue_byte(1'b0, 8'h0C, '0, 13'd1000);
          queue_byte(1'b0, 8'h01, '0, 13'd2000);
          queue_byte(1'b0, 8'h06, '0, 13'd2000);
        end
      end
      clt_pkg::ACT_CMD:    queue_byte(1'b0, bv, '0, '0);
      clt_pkg::ACT_CHAR:   queue_byte(1'b1, bv, '0, '0);
      clt_pkg::ACT_CURSOR: begin
        // rows other than the two lines give nothing; column wraps in 8 bits
        if (row == 2'd0) begin
          queue_byte(1'b0, clt_pkg::LINE0_BASE + {2'b00, col}, '0, '0);
        end else if (row == 2'd1) begin
          queue_byte(1'b0, clt_pkg::LINE1_BASE + {2'b00, col}, '0, '0);
        end
      end
      clt_pkg::ACT_GLYPH:
        queue_byte(1'b0, clt_pkg::CGRAM_BASE + {2'b00, slot, 3'b000}, '0, '0);
      clt_pkg::ACT_NUMBER: queue_number(num);
      default: ;
    endcase
    // flag the final transfer of this request
    if (pending_xfers.size() > before_size) begin
      tail = pending_xfers.pop_back();
      tail.last = 1'b1;
      pending_xfers.push_back(tail);
    end
  endfunction

  // compare one delivered transfer against the oldest expectation
  function automatic void check_transfer();
    xfer_t want;
    xfer_t got;
    got = {register_select_i, bus_value_i, enable_pulse_us_i, wait_before_us_i,
           wait_after_us_i, last_i};
    if (pending_xfers.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected transfer: rs=%0d bus=%h pulse=%0d wb=%0d wa=%0d last=%0d",
                 got.rs, got.bus, got.pulse, got.wait_before, got.wait_after, got.last);
      end
    end else begin
      want = pending_xfers.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10) begin
          $display("transfer mismatch: exp rs=%0d bus=%h pulse=%0d wb=%0d wa=%0d last=%0d",
                   want.rs, want.bus, want.pulse, want.wait_before, want.wait_after,
                   want.last);
          $display("                   got rs=%0d bus=%h pulse=%0d wb=%0d wa=%0d last=%0d",
                   got.rs, got.bus, got.pulse, got.wait_before, got.wait_after, got.last);
        end
      end
    end
  endfunction

  // watch both channels and the mode register at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_bus = 1'b0;
      pending_xfers.delete();
    end else begin
      if (result_strobe_i) begin
        check_transfer();
      end
      if (start_i && !busy_i) begin
        predict_request(action_i, byte_value_i, number_i, row_i, column_i, glyph_slot_i);
      end
      if (nibble_mode_we_i) begin
        four_bit_bus = nibble_mode_i;
      end
    end
    pending_o = pending_xfers.size();
    fail_count_o = errors;
  end

endmodule

/* tb/tb_char_lcd_transfer_sequencer.sv */
module tb_char_lcd_transfer_sequencer;

  // action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  action_i;
  logic [7:0]  byte_value_i;
  logic [15:0] number_i;
  logic [1:0]  row_i;
  logic [5:0]  column_i;
  logic [2:0]  glyph_slot_i;
  logic        nibble_mode_we_i;
  logic        nibble_mode_i;
  logic        result_strobe_o;
  logic        register_select_o;
  logic [7:0]  bus_value_o;
  logic [10:0] enable_pulse_us_o;
  logic [15:0] wait_before_us_o;
  logic [12:0] wait_after_us_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  // bus mode and sender idle share per phase
  logic phase_mode [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int   phase_idle [NUM_PHASES] = '{0, 46, 46, 10, 10, 0};

  char_lcd_transfer_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .byte_value_i      (byte_value_i),
    .number_i          (number_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .glyph_slot_i      (glyph_slot_i),
    .nibble_mode_we_i  (nibble_mode_we_i),
    .nibble_mode_i     (nibble_mode_i),
    .result_strobe_o   (result_strobe_o),
    .register_select_o (register_select_o),
    .bus_value_o       (bus_value_o),
    .enable_pulse_us_o (enable_pulse_us_o),
    .wait_before_us_o  (wait_before_us_o),
    .wait_after_us_o   (wait_after_us_o),
    .last_o            (last_o)
  );

  char_lcd_transfer_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .action_i          (action_i),
    .byte_value_i      (byte_value_i),
    .number_i          (number_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .glyph_slot_i      (glyph_slot_i),
    .nibble_mode_we_i  (nibble_mode_we_i),
    .nibble_mode_i     (nibble_mode_i),
    .result_strobe_i   (result_strobe_o),
    .register_select_i (register_select_o),
    .bus_value_i       (bus_value_o),
    .enable_pulse_us_i (enable_pulse_us_o),
    .wait_before_us_i  (wait_before_us_o),
    .wait_after_us_i   (wait_after_us_o),
    .last_i            (last_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one request and hold it until taken, then maybe go idle
  task automatic issue_request(input logic [2:0] act, input logic [7:0] bv,
                               input logic [15:0] num, input logic [1:0] row,
                               input logic [5:0] col, input logic [2:0] slot,
                               input int idle_pct);
    start_i <= 1'b1;
    action_i <= act;
    byte_value_i <= bv;
    number_i <= num;
    row_i <= row;
    column_i <= col;
    glyph_slot_i <= slot;
    do @(posedge clk_i); while (busy_o);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  // wait until every transfer is in and the block has gone quiet
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_bus_mode(input logic m);
    nibble_mode_i <= m;
    nibble_mode_we_i <= 1'b1;
    @(posedge clk_i);
    nibble_mode_we_i <= 1'b0;
  endtask

  // random request, mostly meaningful, some noise on rows and spare actions
  task automatic random_request(input int idle_pct);
    int          pick;
    logic [2:0]  act;
    logic [15:0] num;
    logic [1:0]  row;
    logic [5:0]  col;
    pick = $urandom_range(99);
    if (pick < 8) act = clt_pkg::ACT_INIT;
    else if (pick < 23) act = clt_pkg::ACT_CMD;
    else if (pick < 40) act = clt_pkg::ACT_CHAR;
    else if (pick < 57) act = clt_pkg::ACT_CURSOR;
    else if (pick < 70) act = clt_pkg::ACT_GLYPH;
    else if (pick < 95) act = clt_pkg::ACT_NUMBER;
    else act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    case ($urandom_range(3))
      0: num = 16'($urandom_range(65535));
      1: num = 16'($urandom_range(9));
      2: num = 16'($urandom_range(999));
      default: num = 16'($urandom_range(655) * 100);
    endcase
    row = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
    col = ($urandom_range(9) < 8) ? 6'($urandom_range(39)) : 6'($urandom_range(63, 40));
    issue_request(act, 8'($urandom), num, row, col, 3'($urandom_range(7)), idle_pct);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = clt_pkg::ACT_INIT;
    byte_value_i = '0;
    number_i = '0;
    row_i = '0;
    column_i = '0;
    glyph_slot_i = '0;
    nibble_mode_we_i = 1'b0;
    nibble_mode_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_bus_mode(1'b0);

    // directed: field extremes, every action, the corner cases
    issue_request(clt_pkg::ACT_INIT,   8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CMD,    8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CMD,    8'hFF, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CHAR,   8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CHAR,   8'hFF, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CURSOR, 8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CURSOR, 8'h00, 16'd0,     2'd1, 6'd39, 3'd0, 0);
    issue_request(clt_pkg::ACT_CURSOR, 8'h00, 16'd0,     2'd1, 6'd63, 3'd0, 0);
    issue_request(clt_pkg::ACT_CURSOR, 8'h00, 16'd0,     2'd2, 6'd5,  3'd0, 0);
    issue_request(clt_pkg::ACT_CURSOR, 8'h00, 16'd0,     2'd3, 6'd63, 3'd0, 0);
    issue_request(clt_pkg::ACT_GLYPH,  8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_GLYPH,  8'h00, 16'd0,     2'd0, 6'd0,  3'd7, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd0,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd65535, 2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd10000, 2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd9,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd100,   2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_NUMBER, 8'h00, 16'd40005, 2'd0, 6'd0,  3'd0, 0);
    issue_request(ACT_SPARE_LO,        8'hFF, 16'd1,     2'd0, 6'd0,  3'd0, 0);
    issue_request(ACT_SPARE_HI,        8'hFF, 16'd1,     2'd0, 6'd0,  3'd0, 0);
    issue_request(clt_pkg::ACT_CHAR,   8'h41, 16'd0,     2'd0, 6'd0,  3'd0, 0);

    // random phases, bus mode changed only while quiet
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_bus_mode(phase_mode[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request(phase_idle[p]);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/clt_pkg.sv
hdl/clt_ctrl.sv
hdl/clt_datapath.sv
hdl/char_lcd_transfer_sequencer.sv
tb/char_lcd_transfer_checker.sv
tb/tb_char_lcd_transfer_sequencer.sv
